/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh : concurrent assertion helpers for the line stepper
// both macros sample on clk and are disarmed while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OLPS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define OLPS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

/* src/olps_pkg.sv */
// ----------------------------------------------------------------------------
// olps_pkg : shared types and constants of the octant line pixel stepper
// operation codes, step direction flags and default widths
// ----------------------------------------------------------------------------
package olps_pkg;

  // default coordinate width and fixed colour width
  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 16;

  // operation carried in tuser
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // step directions of the active line
  typedef struct packed {
    logic major_y;  // major axis is y
    logic y_neg;    // y decreases
    logic x_neg;    // x decreases
  } dirs_t;

endpackage

/* src/olps_setup.sv */
// ----------------------------------------------------------------------------
// olps_setup : line setup for a load transaction
// absolute deltas, octant selection and the initial error term
// ----------------------------------------------------------------------------
module olps_setup #(
  parameter int COORD_BITS = olps_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output olps_pkg::dirs_t       dirs,
  output logic [COORD_BITS-1:0] delta_major,
  output logic [COORD_BITS-1:0] delta_minor,
  output logic [COORD_BITS-1:0] stop_major,
  output logic [COORD_BITS+1:0] err_init
);

  localparam int ERR_W = COORD_BITS + 2;

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;

  // absolute deltas and step directions
  always_comb begin
    dirs.x_neg = (x_end < x_start);
    dirs.y_neg = (y_end < y_start);
    adx = dirs.x_neg ? (x_start - x_end) : (x_end - x_start);
    ady = dirs.y_neg ? (y_start - y_end) : (y_end - y_start);
    // ties go to x
    dirs.major_y = (ady > adx);
  end

  // major and minor axis selection
  always_comb begin
    if (dirs.major_y) begin
      delta_major = ady;
      delta_minor = adx;
      stop_major  = y_end;
    end else begin
      delta_major = adx;
      delta_minor = ady;
      stop_major  = x_end;
    end
  end

  // error starts at minor minus half of major, rounded down
  assign err_init = ERR_W'(delta_minor) - ERR_W'(delta_major >> 1);

endmodule

/* src/octant_line_pixel_stepper.sv */
// ----------------------------------------------------------------------------
// octant_line_pixel_stepper : Bresenham rasteriser for all eight octants
// an accepted advance's pixel is registered and reaches the master side in the next cycle
// throughput 1 transaction per cycle while the output stage is free or draining, one add/compare step per pixel
// synchronous reset clears line state (no line active) and the valid flag of the output stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module octant_line_pixel_stepper #(
  parameter int COORD_BITS = olps_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // slave side
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata, lsb up: x_start, y_start, x_end, y_end, color, zero fill
  input  logic [((4*COORD_BITS+olps_pkg::COLOR_BITS+7)/8)*8-1:0] s_tdata,
  // s_tuser: op
  input  logic s_tuser,
  // master side
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata, lsb up: pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*COORD_BITS+olps_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
  // m_tlast: last_pixel
  output logic m_tlast
);

  localparam int CB    = COORD_BITS;
  localparam int CLR   = olps_pkg::COLOR_BITS;
  localparam int ERR_W = CB + 2;
  localparam int OUT_W = ((2*CB + CLR + 7) / 8) * 8;

  // unpacked input fields
  olps_pkg::op_t   op;
  logic [CB-1:0]   x_start;
  logic [CB-1:0]   y_start;
  logic [CB-1:0]   x_end;
  logic [CB-1:0]   y_end;
  logic [CLR-1:0]  color;

  // line state
  logic [CB-1:0]    cur_x;
  logic [CB-1:0]    cur_y;
  logic [CB-1:0]    stop_major;
  logic [ERR_W-1:0] err_term;
  logic [CB-1:0]    delta_major;
  logic [CB-1:0]    delta_minor;
  olps_pkg::dirs_t  step_dirs;
  logic [CLR-1:0]   line_color;
  logic             busy;

  // setup results
  olps_pkg::dirs_t  set_dirs;
  logic [CB-1:0]    set_major;
  logic [CB-1:0]    set_minor;
  logic [CB-1:0]    set_stop;
  logic [ERR_W-1:0] set_err;

  // step logic
  logic             s_accept;
  logic             do_load;
  logic             do_emit;
  logic [CB-1:0]    major_now;
  logic             is_last;
  logic             err_pos;
  logic [CB-1:0]    cur_x_next;
  logic [CB-1:0]    cur_y_next;
  logic [ERR_W-1:0] err_term_next;

  // output stage
  logic [CB-1:0]    out_x;
  logic [CB-1:0]    out_y;
  logic [CLR-1:0]   out_color;
  logic             out_last;

  // field unpacking
  assign op      = olps_pkg::op_t'(s_tuser);
  assign x_start = s_tdata[CB-1:0];
  assign y_start = s_tdata[2*CB-1:CB];
  assign x_end   = s_tdata[3*CB-1:2*CB];
  assign y_end   = s_tdata[4*CB-1:3*CB];
  assign color   = s_tdata[4*CB+CLR-1:4*CB];

  // handshake: take a transaction whenever the output stage is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign do_load  = s_accept && (op == olps_pkg::OP_LOAD);
  assign do_emit  = s_accept && (op == olps_pkg::OP_ADVANCE) && busy;

  olps_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .dirs        (set_dirs),
    .delta_major (set_major),
    .delta_minor (set_minor),
    .stop_major  (set_stop),
    .err_init    (set_err)
  );

  // one Bresenham step from the current pixel
  always_comb begin
    major_now  = step_dirs.major_y ? cur_y : cur_x;
    is_last    = (major_now == stop_major);
    err_pos    = !err_term[ERR_W-1] && (err_term != '0);
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (step_dirs.major_y) begin
      cur_y_next = step_dirs.y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      if (err_pos) begin
        cur_x_next = step_dirs.x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
    end else begin
      cur_x_next = step_dirs.x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      if (err_pos) begin
        cur_y_next = step_dirs.y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end
    err_term_next = err_term + ERR_W'(delta_minor)
                  - (err_pos ? ERR_W'(delta_major) : '0);
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      stop_major  <= '0;
      err_term    <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      step_dirs   <= '0;
      line_color  <= '0;
      busy        <= 1'b0;
    end else if (do_load) begin
      cur_x       <= x_start;
      cur_y       <= y_start;
      stop_major  <= set_stop;
      err_term    <= set_err;
      delta_major <= set_major;
      delta_minor <= set_minor;
      step_dirs   <= set_dirs;
      line_color  <= color;
      busy        <= 1'b1;
    end else if (do_emit) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        cur_x    <= cur_x_next;
        cur_y    <= cur_y_next;
        err_term <= err_term_next;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_x     <= cur_x;
      out_y     <= cur_y;
      out_color <= line_color;
      out_last  <= is_last;
    end
  end

  assign m_tdata = OUT_W'({out_color, out_y, out_x});
  assign m_tlast = out_last;

  // checks
  `OLPS_ASSERT_NEXT(a_last_ends_line, do_emit && is_last,
                    !busy && m_tvalid && m_tlast, "last pixel did not end the line")
  `OLPS_ASSERT_NEXT(a_load_starts_line, do_load,
                    busy && cur_x == $past(x_start) && cur_y == $past(y_start),
                    "load did not start a line at its first endpoint")
  `OLPS_ASSERT_NOW(a_idle_advance_silent,
                   s_accept && op == olps_pkg::OP_ADVANCE && !busy,
                   !do_emit, "advance while idle produced a pixel")

endmodule
